/* sv/kte_pkg.sv */
// shared types and constants for the k-nearest-neighbor search block
// no dependencies

package kte_pkg;

    localparam int KIND_W     = 2;
    localparam int VALUE_W    = 16;
    localparam int INDEX_W    = 32;
    localparam int DIM_W      = 7;
    localparam int NBR_W      = 5;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    // input item kinds
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_DIMENSION      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NEIGHBOR_COUNT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_INDEX_BASE     = 2'd2;

    // classified item as held in the front queue
    typedef struct packed {
        logic               is_query;
        logic               is_data;
        logic               is_end;
        logic [VALUE_W-1:0] value;
    } t_item;

endpackage

/* sv/kte_if.sv */
// channel interfaces: item input, result output, configuration write
// depends on kte_pkg

interface kte_in_if;
    logic                       valid;
    logic                       ready;
    logic [kte_pkg::KIND_W-1:0] kind;
    logic [kte_pkg::VALUE_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface kte_out_if;
    logic                        valid;
    logic                        ready;
    logic [kte_pkg::INDEX_W-1:0] hit_index;
    logic                        last;

    modport source (output valid, output hit_index, output last, input ready);
    modport sink   (input valid, input hit_index, input last, output ready);
endinterface

interface kte_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [kte_pkg::CFG_ADDR_W-1:0] index;
    logic [kte_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/knn_top_k_euclidean_top.sv */
// k-nearest-neighbor search by squared euclidean distance, top level
// depends on kte_pkg, kte_if, kte_front, kte_dist, kte_rank

// Load the query with kind 0 items, stream database coordinates with kind 1
// items, then send a kind 2 item to read out the held neighbor indices, farthest
// first, with last on the final one. Items pass through a four-entry queue into
// a three-stage distance pipeline (query store read, square, accumulate) and a
// sorted register array that inserts one finished vector per cycle, so query
// and database coordinates go at one per cycle while no readout is under way. An
// end item waits for the distance pipeline to drain, then the results leave at
// one per cycle from an output register while the receiver is ready; items behind
// it wait until the last result is loaded. Configuration writes are always ready.

module knn_top_k_euclidean_top #(
    parameter int MAX_DIM = 64,
    parameter int MAX_K   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kte_in_if.sink    i_in,
    kte_out_if.source o_out,
    kte_cfg_if.sink   i_cfg
);

    localparam int AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int SUM_W = 34 + AW;

    logic [kte_pkg::DIM_W-1:0]   r_dimension;
    logic [kte_pkg::NBR_W-1:0]   r_neighbor_count;
    logic [kte_pkg::INDEX_W-1:0] r_index_base;

    kte_pkg::t_item              w_item;
    logic                        w_item_valid;
    logic                        w_item_pop;
    logic                        w_end;
    logic                        w_busy;
    logic                        w_off_valid;
    logic [SUM_W-1:0]            w_off_dist;
    logic [kte_pkg::INDEX_W-1:0] w_off_idx;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dimension      <= kte_pkg::DIM_W'(1);
            r_neighbor_count <= kte_pkg::NBR_W'(1);
            r_index_base     <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                kte_pkg::CFG_DIMENSION:      r_dimension      <= i_cfg.data[kte_pkg::DIM_W-1:0];
                kte_pkg::CFG_NEIGHBOR_COUNT: r_neighbor_count <= i_cfg.data[kte_pkg::NBR_W-1:0];
                kte_pkg::CFG_INDEX_BASE:     r_index_base     <= i_cfg.data;
                default: ;
            endcase
        end
    end

    kte_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_item_pop   (w_item_pop)
    );

    kte_dist #(
        .MAX_DIM (MAX_DIM),
        .SUM_W   (SUM_W)
    ) u_dist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_item_pop   (w_item_pop),
        .i_dimension  (r_dimension),
        .i_index_base (r_index_base),
        .i_rank_busy  (w_busy),
        .o_end        (w_end),
        .o_off_valid  (w_off_valid),
        .o_off_dist   (w_off_dist),
        .o_off_idx    (w_off_idx)
    );

    kte_rank #(
        .MAX_K (MAX_K),
        .SUM_W (SUM_W)
    ) u_rank (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_neighbor_count (r_neighbor_count),
        .i_off_valid      (w_off_valid),
        .i_off_dist       (w_off_dist),
        .i_off_idx        (w_off_idx),
        .i_end            (w_end),
        .o_busy           (w_busy),
        .o_out            (o_out)
    );

endmodule

/* sv/kte_front.sv */
// front end: accepts input transfers, classifies the kind, queues items
// depends on kte_pkg and kte_in_if

module kte_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    kte_in_if.sink         i_in,
    output kte_pkg::t_item o_item,
    output logic           o_item_valid,
    input  logic           i_item_pop
);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    kte_pkg::t_item   r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QAW:0]     r_cnt, n_cnt;
    kte_pkg::t_item   w_item;
    logic             w_push;
    logic             w_pop;

    assign i_in.ready   = (r_cnt != (QAW+1)'(QDEPTH));
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        w_item.is_query = (i_in.kind == kte_pkg::KIND_QUERY);
        w_item.is_data  = (i_in.kind == kte_pkg::KIND_DATA);
        w_item.is_end   = (i_in.kind == kte_pkg::KIND_END);
        w_item.value    = i_in.value;
    end

    // unknown kinds are taken and dropped
    assign w_push = i_in.valid && i_in.ready &&
                    (w_item.is_query || w_item.is_data || w_item.is_end);
    assign w_pop  = i_item_pop && o_item_valid;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        unique case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

/* sv/kte_dist.sv */
// distance pipeline: query store, coordinate difference, square, accumulate
// depends on kte_pkg

module kte_dist #(
    parameter int MAX_DIM = 64,
    parameter int SUM_W   = 40
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  kte_pkg::t_item               i_item,
    input  logic                         i_item_valid,
    output logic                         o_item_pop,
    input  logic [kte_pkg::DIM_W-1:0]    i_dimension,
    input  logic [kte_pkg::INDEX_W-1:0]  i_index_base,
    input  logic                         i_rank_busy,
    output logic                         o_end,
    output logic                         o_off_valid,
    output logic [SUM_W-1:0]             o_off_dist,
    output logic [kte_pkg::INDEX_W-1:0]  o_off_idx
);

    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int VW = kte_pkg::VALUE_W;

    logic [VW-1:0]               r_qmem [MAX_DIM];
    logic [AW-1:0]               r_fill;
    logic [AW-1:0]               r_pos;
    logic [kte_pkg::INDEX_W-1:0] r_vn;

    logic                        r_b_valid;
    logic [VW-1:0]               r_b_value;
    logic [VW-1:0]               r_b_q;
    logic                        r_b_last;
    logic [kte_pkg::INDEX_W-1:0] r_b_idx;

    logic                        r_c_valid;
    logic [31:0]                 r_c_sq;
    logic                        r_c_last;
    logic [kte_pkg::INDEX_W-1:0] r_c_idx;

    logic [SUM_W-1:0]            r_sum;
    logic                        r_off_valid;
    logic [SUM_W-1:0]            r_off_dist;
    logic [kte_pkg::INDEX_W-1:0] r_off_idx;

    logic [AW:0]                 w_eff;
    logic                        w_empty;
    logic                        w_go;
    logic [AW-1:0]               w_q_addr;
    logic [AW:0]                 w_q_inc;
    logic [AW-1:0]               w_q_next;
    logic [AW:0]                 w_pos_inc;
    logic                        w_pos_last;
    logic signed [VW:0]          w_diff;
    logic signed [2*VW+1:0]      w_sq;
    logic [SUM_W-1:0]            w_sum;

    always_comb begin
        if (i_dimension == '0) begin
            w_eff = (AW+1)'(1);
        end else if (int'(i_dimension) > MAX_DIM) begin
            w_eff = (AW+1)'(MAX_DIM);
        end else begin
            w_eff = (AW+1)'(i_dimension);
        end
    end

    assign w_empty = !r_b_valid && !r_c_valid && !r_off_valid;
    assign w_go    = i_item_valid && !i_rank_busy && (!i_item.is_end || w_empty);
    assign o_item_pop = w_go;
    assign o_end      = w_go && i_item.is_end;

    // query write address, wraps when the dimension was lowered
    assign w_q_addr   = ({1'b0, r_fill} >= w_eff) ? '0 : r_fill;
    assign w_q_inc    = {1'b0, w_q_addr} + (AW+1)'(1);
    assign w_q_next   = (w_q_inc >= w_eff) ? '0 : w_q_inc[AW-1:0];
    assign w_pos_inc  = {1'b0, r_pos} + (AW+1)'(1);
    assign w_pos_last = (w_pos_inc >= w_eff);

    assign w_diff = $signed({r_b_value[VW-1], r_b_value}) - $signed({r_b_q[VW-1], r_b_q});
    assign w_sq   = w_diff * w_diff;
    assign w_sum  = r_sum + SUM_W'(r_c_sq);

    always_ff @(posedge i_clk) begin
        if (w_go && i_item.is_query) begin
            r_qmem[w_q_addr] <= i_item.value;
        end
        if (w_go && i_item.is_data) begin
            r_b_q <= r_qmem[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_pos       <= '0;
            r_vn        <= '0;
            r_sum       <= '0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_off_valid <= 1'b0;
        end else begin
            r_b_valid   <= w_go && i_item.is_data;
            r_c_valid   <= r_b_valid;
            r_off_valid <= r_c_valid && r_c_last;
            if (w_go && i_item.is_query) begin
                r_fill <= w_q_next;
            end
            if (w_go && i_item.is_data) begin
                r_pos <= w_pos_last ? '0 : w_pos_inc[AW-1:0];
                if (w_pos_last) begin
                    r_vn <= r_vn + 1'b1;
                end
            end
            if (w_go && i_item.is_end) begin
                r_fill <= '0;
                r_pos  <= '0;
                r_vn   <= '0;
                r_sum  <= '0;
            end else if (r_c_valid) begin
                r_sum <= r_c_last ? '0 : w_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_value  <= i_item.value;
        r_b_last   <= w_pos_last;
        r_b_idx    <= i_index_base + r_vn;
        r_c_sq     <= w_sq[31:0];
        r_c_last   <= r_b_last;
        r_c_idx    <= r_b_idx;
        r_off_dist <= w_sum;
        r_off_idx  <= r_c_idx;
    end

    assign o_off_valid = r_off_valid;
    assign o_off_dist  = r_off_dist;
    assign o_off_idx   = r_off_idx;

endmodule

/* sv/kte_rank.sv */
// ranking: sorted register array of the best distances, result emission
// depends on kte_pkg and kte_out_if

module kte_rank #(
    parameter int MAX_K = 16,
    parameter int SUM_W = 40
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [kte_pkg::NBR_W-1:0]    i_neighbor_count,
    input  logic                         i_off_valid,
    input  logic [SUM_W-1:0]             i_off_dist,
    input  logic [kte_pkg::INDEX_W-1:0]  i_off_idx,
    input  logic                         i_end,
    output logic                         o_busy,
    kte_out_if.source                    o_out
);

    localparam int CW = $clog2(MAX_K + 1);
    localparam int IW = kte_pkg::INDEX_W;

    // entry 0 holds the largest (distance, index) pair
    logic [SUM_W-1:0] r_dist [MAX_K];
    logic [IW-1:0]    r_idx  [MAX_K];
    logic [CW-1:0]    r_count;
    logic             r_emitting;
    logic             r_out_valid;
    logic [IW-1:0]    r_out_idx;
    logic             r_out_last;

    logic [SUM_W-1:0] n_dist [MAX_K];
    logic [IW-1:0]    n_idx  [MAX_K];
    logic [SUM_W-1:0] w_sh_dist [MAX_K];
    logic [IW-1:0]    w_sh_idx  [MAX_K];
    logic [MAX_K-1:0] w_gt;
    logic [MAX_K:0]   w_gt_lo;
    logic [MAX_K:0]   w_gt_hi;
    logic [CW-1:0]    w_eff_k;
    logic             w_full;
    logic             w_skip;
    logic             w_take;
    logic             w_load;

    always_comb begin
        if (i_neighbor_count == '0) begin
            w_eff_k = CW'(1);
        end else if (int'(i_neighbor_count) > MAX_K) begin
            w_eff_k = CW'(MAX_K);
        end else begin
            w_eff_k = CW'(i_neighbor_count);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_K; i++) begin
            w_gt[i] = (CW'(i) < r_count) &&
                      ((r_dist[i] > i_off_dist) ||
                       ((r_dist[i] == i_off_dist) && (r_idx[i] > i_off_idx)));
        end
    end

    assign w_gt_lo = {w_gt, 1'b1};
    assign w_gt_hi = {1'b0, w_gt};
    assign w_full  = (r_count >= w_eff_k);
    assign w_skip  = w_full && (i_off_dist > r_dist[0]);
    assign w_take  = i_off_valid && !w_skip;
    assign w_load  = r_emitting && (r_count != '0) && (!r_out_valid || o_out.ready);

    always_comb begin
        int j_dn;
        int j_up;
        for (int i = 0; i < MAX_K; i++) begin
            j_dn = (i == 0) ? 0 : i - 1;
            j_up = (i == MAX_K - 1) ? i : i + 1;
            w_sh_dist[i] = r_dist[j_up];
            w_sh_idx[i]  = r_idx[j_up];
            if (w_full) begin
                // drop entry 0 and insert the new pair in order
                if (w_gt_hi[i+1]) begin
                    n_dist[i] = r_dist[j_up];
                    n_idx[i]  = r_idx[j_up];
                end else if (w_gt[i] || (i == 0)) begin
                    n_dist[i] = i_off_dist;
                    n_idx[i]  = i_off_idx;
                end else begin
                    n_dist[i] = r_dist[i];
                    n_idx[i]  = r_idx[i];
                end
            end else begin
                if (w_gt[i]) begin
                    n_dist[i] = r_dist[i];
                    n_idx[i]  = r_idx[i];
                end else if (w_gt_lo[i]) begin
                    n_dist[i] = i_off_dist;
                    n_idx[i]  = i_off_idx;
                end else begin
                    n_dist[i] = r_dist[j_dn];
                    n_idx[i]  = r_idx[j_dn];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_dist <= n_dist;
            r_idx  <= n_idx;
        end else if (w_load) begin
            r_dist <= w_sh_dist;
            r_idx  <= w_sh_idx;
        end
        if (w_load) begin
            r_out_idx  <= r_idx[0];
            r_out_last <= (r_count == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_emitting  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take && !w_full) begin
                r_count <= r_count + 1'b1;
            end else if (w_load) begin
                r_count <= r_count - 1'b1;
            end
            if (i_end) begin
                r_emitting <= 1'b1;
            end else if (r_emitting && (r_count == '0)) begin
                r_emitting <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_busy          = r_emitting;
    assign o_out.valid     = r_out_valid;
    assign o_out.hit_index = r_out_idx;
    assign o_out.last      = r_out_last;

endmodule

/* sv/kte_checker.sv */
// port-level checks for the k-nearest-neighbor search block, with its bind
// depends on knn_top_k_euclidean_top

module kte_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_hit_index,
    input logic        i_out_last,
    input logic        i_cfg_ready
);

    // no result shows right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_hit_index) && $stable(i_out_last))
        else $error("stalled result changed");

    // results of one run follow back to back until last
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_valid)
        else $error("result run broke before last");

    // configuration never stalls
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |-> i_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind knn_top_k_euclidean_top kte_checker u_kte_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_hit_index (o_out.hit_index),
    .i_out_last      (o_out.last),
    .i_cfg_ready     (i_cfg.ready)
);

/* verif/tb_top.sv */
// testbench for knn_top_k_euclidean_top: directed and random k-nearest-neighbor searches,
// checked against a cycle-free predictor of the neighbor set and its readout order
// depends on kte_pkg, kte_if and the knn_top_k_euclidean_top rtl
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_DIM        = 64;
    localparam int MAX_K          = 16;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET    = 360;
    localparam logic [kte_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [kte_pkg::INDEX_W-1:0] hit_index;
        logic                        last;
    } t_hit;

    logic i_clk;
    logic i_rst_n;

    kte_in_if  item_ch();
    kte_out_if hit_ch();
    kte_cfg_if cfg_ch();

    knn_top_k_euclidean_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (item_ch),
        .o_out   (hit_ch),
        .i_cfg   (cfg_ch)
    );

    // predicted search state
    logic [kte_pkg::DIM_W-1:0]          dim_r  = 7'd1;
    logic [kte_pkg::NBR_W-1:0]          nbr_r  = 5'd1;
    logic [kte_pkg::INDEX_W-1:0]        base_r = '0;
    logic signed [kte_pkg::VALUE_W-1:0] query_coord [MAX_DIM];
    int unsigned                        query_fill = 0;
    int unsigned                        coord_pos  = 0;
    logic [39:0]                        partial_sum = '0;
    logic [31:0]                        vector_num  = '0;
    logic [39:0]                        best_dist [MAX_K];
    logic [kte_pkg::INDEX_W-1:0]        best_idx  [MAX_K];
    int unsigned                        best_n = 0;

    t_hit expected_hits [$];

    bit idle_on        = 1'b1;
    int hold_cycles    = 0;
    int items_sent     = 0;
    int hits_checked   = 0;
    int search_ends    = 0;
    int cfg_writes     = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_dim();
        if (dim_r == 0) return 1;
        if (dim_r > MAX_DIM) return MAX_DIM;
        return dim_r;
    endfunction

    function automatic int unsigned eff_k();
        if (nbr_r == 0) return 1;
        if (nbr_r > MAX_K) return MAX_K;
        return nbr_r;
    endfunction

    function automatic bit pair_greater(logic [39:0] da, logic [kte_pkg::INDEX_W-1:0] ia,
                                        logic [39:0] db, logic [kte_pkg::INDEX_W-1:0] ib);
        return (da > db) || (da == db && ia > ib);
    endfunction

    function automatic void queue_hit(t_hit h);
        expected_hits = {expected_hits, h};
    endfunction

    function automatic void keep_nearest(logic [39:0] dist_v,
                                         logic [kte_pkg::INDEX_W-1:0] idx);
        int unsigned top;
        top = 0;
        if (best_n < eff_k()) begin
            if (best_n < MAX_K) begin
                best_dist[best_n] = dist_v;
                best_idx[best_n]  = idx;
                best_n++;
            end
            return;
        end
        for (int i = 1; i < best_n && i < MAX_K; i++)
            if (pair_greater(best_dist[i], best_idx[i], best_dist[top], best_idx[top]))
                top = i;
        if (dist_v > best_dist[top]) return;
        best_dist[top] = dist_v;
        best_idx[top]  = idx;
    endfunction

    function automatic void emit_neighbors();
        logic [39:0]                 dist_copy [MAX_K];
        logic [kte_pkg::INDEX_W-1:0] idx_copy  [MAX_K];
        logic [39:0]                 td;
        logic [kte_pkg::INDEX_W-1:0] tx;
        int unsigned                 n, m;
        t_hit                        h;
        n = (best_n > MAX_K) ? MAX_K : best_n;
        dist_copy = best_dist;
        idx_copy  = best_idx;
        for (int i = 0; i < n; i++) begin
            m = i;
            for (int j = i + 1; j < n; j++)
                if (pair_greater(dist_copy[j], idx_copy[j], dist_copy[m], idx_copy[m])) m = j;
            td = dist_copy[i]; tx = idx_copy[i];
            dist_copy[i] = dist_copy[m]; idx_copy[i] = idx_copy[m];
            dist_copy[m] = td; idx_copy[m] = tx;
            h.hit_index = idx_copy[i];
            h.last      = (i + 1 == n);
            queue_hit(h);
        end
        best_n      = 0;
        vector_num  = '0;
        coord_pos   = 0;
        partial_sum = '0;
        query_fill  = 0;
        search_ends++;
    endfunction

    function automatic void update_search(logic [kte_pkg::KIND_W-1:0] kind_v,
                                          logic [kte_pkg::VALUE_W-1:0] value_v);
        int unsigned pos;
        longint      diff;
        case (kind_v)
            kte_pkg::KIND_QUERY: begin
                if (query_fill >= eff_dim()) query_fill = 0;
                query_coord[query_fill] = value_v;
                query_fill++;
                if (query_fill >= eff_dim()) query_fill = 0;
            end
            kte_pkg::KIND_DATA: begin
                pos = (coord_pos >= MAX_DIM) ? MAX_DIM - 1 : coord_pos;
                diff = longint'($signed(value_v)) - longint'(query_coord[pos]);
                partial_sum = partial_sum + 40'(diff * diff);
                coord_pos = pos + 1;
                if (coord_pos >= eff_dim()) begin
                    keep_nearest(partial_sum, base_r + vector_num);
                    vector_num++;
                    partial_sum = '0;
                    coord_pos   = 0;
                end
            end
            kte_pkg::KIND_END: emit_neighbors();
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && item_ch.valid && item_ch.ready)
            update_search(item_ch.kind, item_ch.value);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready) begin
            case (cfg_ch.index)
                kte_pkg::CFG_DIMENSION:      dim_r  = cfg_ch.data[kte_pkg::DIM_W-1:0];
                kte_pkg::CFG_NEIGHBOR_COUNT: nbr_r  = cfg_ch.data[kte_pkg::NBR_W-1:0];
                kte_pkg::CFG_INDEX_BASE:     base_r = cfg_ch.data[kte_pkg::INDEX_W-1:0];
                default: ;
            endcase
            cfg_writes++;
        end
    end

    // result checking
    always @(posedge i_clk) begin
        t_hit want;
        if (i_rst_n && hit_ch.valid && hit_ch.ready) begin
            hits_checked++;
            if (expected_hits.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result index %h last %b",
                             $time, hit_ch.hit_index, hit_ch.last);
            end else begin
                want = expected_hits.pop_front();
                if (hit_ch.hit_index !== want.hit_index || hit_ch.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch, expected index %h last %b, got index %h last %b",
                                 $time, want.hit_index, want.last,
                                 hit_ch.hit_index, hit_ch.last);
                end
            end
        end
    end

    // receiver, with random idling and long holds on request
    initial begin
        forever begin
            if (hold_cycles > 0) begin
                hit_ch.ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                hit_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                hit_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (hit_ch.valid && hit_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("knn_top_k_euclidean_top verification failed");
            $finish;
        end
    end

    task automatic send_item(input logic [kte_pkg::KIND_W-1:0] kind_v,
                             input logic [kte_pkg::VALUE_W-1:0] value_v);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.kind  <= kind_v;
        item_ch.value <= value_v;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        if (kind_v != KIND_UNUSED) items_sent++;
    endtask

    task automatic write_reg(input logic [kte_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [kte_pkg::CFG_DATA_W-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    task automatic configure(input logic [31:0] dim_w, input logic [31:0] k_w,
                             input logic [31:0] base_w);
        write_reg(kte_pkg::CFG_DIMENSION, dim_w);
        write_reg(kte_pkg::CFG_NEIGHBOR_COUNT, k_w);
        write_reg(kte_pkg::CFG_INDEX_BASE, base_w);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait until every predicted neighbor has arrived and the pipeline is empty
    task automatic settle();
        item_ch.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (expected_hits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [kte_pkg::VALUE_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            1, 2:    return 16'($urandom_range(0, 3));
            default: return 16'($urandom());
        endcase
    endfunction

    // full query load, n_vec database vectors with some noise, optional partial tail, end
    task automatic stream_search(input int n_vec);
        int unsigned d;
        d = eff_dim();
        repeat (($urandom_range(0, 5) == 0) ? 2 * d : d)
            send_item(kte_pkg::KIND_QUERY, pick_coord());
        for (int v = 0; v < n_vec; v++) begin
            for (int c = 0; c < d; c++) begin
                case ($urandom_range(0, 39))
                    0: send_item(KIND_UNUSED, 16'($urandom()));
                    1: send_item(kte_pkg::KIND_QUERY, pick_coord());
                    default: ;
                endcase
                send_item(kte_pkg::KIND_DATA, pick_coord());
            end
        end
        if (d > 1 && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, d - 1)) send_item(kte_pkg::KIND_DATA, pick_coord());
        send_item(kte_pkg::KIND_END, 16'($urandom()));
    endtask

    task automatic random_search();
        logic [31:0] dim_w, k_w, base_w;
        int unsigned d;
        settle();
        case ($urandom_range(0, 9))
            0:       dim_w = 32'd0;
            1:       dim_w = $urandom_range(6, 12);
            default: dim_w = $urandom_range(1, 5);
        endcase
        case ($urandom_range(0, 9))
            0:       k_w = 32'd0;
            1:       k_w = $urandom_range(17, 31);
            default: k_w = $urandom_range(1, 16);
        endcase
        if ($urandom_range(0, 3) == 0) dim_w[31:7] = 25'($urandom());
        if ($urandom_range(0, 3) == 0) k_w[31:5] = 27'($urandom());
        base_w = ($urandom_range(0, 4) == 0) ? 32'hffff_ffff - $urandom_range(0, 8) : $urandom();
        d = (dim_w[6:0] == 0) ? 1 : dim_w[6:0];
        configure(dim_w, k_w, base_w);
        stream_search(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, (d <= 4) ? 24 : 8));
    endtask

    task automatic test_extremes_and_wrap();
        configure(32'd2, 32'd3, 32'hffff_fffe);
        send_item(kte_pkg::KIND_QUERY, 16'h1234);
        send_item(kte_pkg::KIND_QUERY, 16'h4321);
        // query wraps and is overwritten from its first coordinate
        send_item(kte_pkg::KIND_QUERY, 16'h8000);
        send_item(kte_pkg::KIND_QUERY, 16'h7fff);
        send_item(kte_pkg::KIND_DATA, 16'h7fff);
        send_item(kte_pkg::KIND_DATA, 16'h8000);
        repeat (2) begin
            send_item(kte_pkg::KIND_DATA, 16'h8000);
            send_item(kte_pkg::KIND_DATA, 16'h7fff);
        end
        send_item(kte_pkg::KIND_DATA, 16'h0000);
        send_item(kte_pkg::KIND_DATA, 16'h0000);
        send_item(KIND_UNUSED, 16'hffff);
        send_item(kte_pkg::KIND_DATA, 16'h5555);
        send_item(kte_pkg::KIND_END, 16'h0000);
        // nothing held
        send_item(kte_pkg::KIND_END, 16'hffff);
        settle();
    endtask

    task automatic test_midsearch_changes();
        configure(32'd3, 32'd6, $urandom());
        repeat (3) send_item(kte_pkg::KIND_QUERY, pick_coord());
        repeat (11) send_item(kte_pkg::KIND_DATA, pick_coord());
        settle();
        // dimension lowered mid-vector, count lowered below the held set
        configure(32'd2, 32'd2, $urandom());
        send_item(kte_pkg::KIND_DATA, pick_coord());
        send_item(kte_pkg::KIND_QUERY, pick_coord());
        repeat (4) send_item(kte_pkg::KIND_DATA, pick_coord());
        send_item(kte_pkg::KIND_END, 16'h0000);
        settle();
    endtask

    task automatic test_clamped_settings();
        configure(32'hffff_ff80, 32'hffff_ffff, 32'hffff_fff8);
        stream_search(24);
        settle();
        configure(32'h0000_00ff, 32'h0000_0000, $urandom());
        stream_search(1);
        settle();
    endtask

    task automatic test_backpressure();
        configure(32'd2, 32'd8, $urandom());
        hold_cycles = 120;
        stream_search(10);
        stream_search(6);
        // sender pauses until all neighbors are out, then goes on with the same settings
        settle();
        stream_search(5);
        settle();
    endtask

    task automatic test_random();
        do random_search(); while (items_sent < ITEM_TARGET - 80);
        settle();
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        do random_search(); while (items_sent < ITEM_TARGET);
        settle();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.kind  <= kte_pkg::KIND_QUERY;
        item_ch.value <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= kte_pkg::CFG_DIMENSION;
        cfg_ch.data   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes_and_wrap();
        test_midsearch_changes();
        test_clamped_settings();
        test_backpressure();
        test_random();
        test_full_rate();

        $display("covered %0d items over %0d searches, %0d neighbor results, %0d register writes",
                 items_sent, search_ends, hits_checked, cfg_writes);
        $display("%0d mismatches, %0d results still pending", mismatch_count,
                 expected_hits.size());
        if (mismatch_count == 0 && expected_hits.size() == 0)
            $display("knn_top_k_euclidean_top verification clean");
        else
            $display("knn_top_k_euclidean_top verification failed");
        $finish;
    end

endmodule
